// ===== hw/rtl/cau_pkg.sv =====
// Package for the complex arithmetic unit: beat types, stage types, widths and
// the shared saturation function. Depends on nothing.
package cau_pkg;

  // Fraction bits of the signed fixed-point format.
  localparam int FRAC_BITS = 16;
  // Quotient bits produced by the divider, one per step stage.
  localparam int QBITS = 32;
  // Width of a dividend scaled up by the fraction bits.
  localparam int NW = 64 + FRAC_BITS;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_NEG  = 3'd5,
    OP_MAG  = 3'd6
  } cau_op_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               zero_divisor;
    logic               saturated;
  } cau_out_t;

  // One lane of the divider: partial remainder, and the dividend bits still to
  // come shifting out at the top while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [63:0]      rem;
    logic [QBITS-1:0] lowq;
    logic             neg;
    logic             big;
  } cau_dlane_t;

  typedef struct packed {
    cau_dlane_t  re;
    cau_dlane_t  im;
    logic [63:0] d;
    logic        is_div;
    logic        zd;
    logic [31:0] pre_re;
    logic [31:0] pre_im;
    logic        pre_sat;
  } cau_dstage_t;

  // Clamp a sign-magnitude value to the signed 32-bit range.
  // Returns the clamp flag above the 32-bit two's complement value.
  function automatic logic [32:0] sat32(input logic neg, input logic [64:0] m);
    logic [32:0] r;
    if (!neg) begin
      if (m > 65'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else                     r = {1'b0, m[31:0]};
    end else begin
      if (m > 65'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else                     r = {1'b0, 32'h0 - m[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cau_front.sv =====
// Front end of the complex arithmetic unit: operand magnitudes, the six
// multipliers, the sign-magnitude sums and the divider set-up. Uses cau_pkg.
module cau_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  cau_pkg::cau_in_t     data_i,
  output logic                 valid_o,
  output cau_pkg::cau_dstage_t data_o
);
  import cau_pkg::*;

  localparam logic [64:0] RND_HALF = (FRAC_BITS == 0) ? 65'd0 : (65'd1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic [2:0]  kind;
    logic        s_ar, s_ai, s_br, s_bi;
    logic [31:0] m_ar, m_ai, m_br, m_bi;
  } opnd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        s_ar, s_ai, s_br, s_bi;
    logic [31:0] m_ar, m_ai, m_br, m_bi;
    logic [63:0] p_rr, p_ii, p_ri, p_ir, p_sr, p_si;
  } prod_t;

  typedef struct packed {
    logic        is_div;
    logic        is_scaled;
    logic        zd;
    logic        s_re;
    logic [63:0] m_re;
    logic        s_im;
    logic [63:0] m_im;
    logic [63:0] d;
  } comb_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'h0 - v) : v;
  endfunction

  // Signed-magnitude sum; returns the sign above the magnitude.
  function automatic logic [64:0] sm_add(input logic sa, input logic [63:0] ma,
                                         input logic sb, input logic [63:0] mb);
    logic [64:0] r;
    if (sa == sb)      r = {sa, ma + mb};
    else if (ma >= mb) r = {sa, ma - mb};
    else               r = {sb, mb - ma};
    return r;
  endfunction

  opnd_t a_d, a_q;
  prod_t b_d, b_q;
  comb_t c_d, c_q;
  cau_dstage_t e_d, e_q;
  logic va_q, vb_q, vc_q, ve_q;

  // Stage A: split the operands into sign and magnitude.
  always_comb begin
    a_d.kind = data_i.kind;
    a_d.s_ar = data_i.a_re[31];
    a_d.s_ai = data_i.a_im[31];
    a_d.s_br = data_i.b_re[31];
    a_d.s_bi = data_i.b_im[31];
    a_d.m_ar = mag32(data_i.a_re);
    a_d.m_ai = mag32(data_i.a_im);
    a_d.m_br = mag32(data_i.b_re);
    a_d.m_bi = mag32(data_i.b_im);
  end

  // Stage B: cross products, and squares of b (of a for the squared magnitude).
  always_comb begin
    logic [31:0] sq_r, sq_i;
    sq_r = (cau_op_e'(a_q.kind) == OP_MAG) ? a_q.m_ar : a_q.m_br;
    sq_i = (cau_op_e'(a_q.kind) == OP_MAG) ? a_q.m_ai : a_q.m_bi;
    b_d.kind = a_q.kind;
    b_d.s_ar = a_q.s_ar;
    b_d.s_ai = a_q.s_ai;
    b_d.s_br = a_q.s_br;
    b_d.s_bi = a_q.s_bi;
    b_d.m_ar = a_q.m_ar;
    b_d.m_ai = a_q.m_ai;
    b_d.m_br = a_q.m_br;
    b_d.m_bi = a_q.m_bi;
    b_d.p_rr = 64'(a_q.m_ar) * 64'(a_q.m_br);
    b_d.p_ii = 64'(a_q.m_ai) * 64'(a_q.m_bi);
    b_d.p_ri = 64'(a_q.m_ar) * 64'(a_q.m_bi);
    b_d.p_ir = 64'(a_q.m_ai) * 64'(a_q.m_br);
    b_d.p_sr = 64'(sq_r) * 64'(sq_r);
    b_d.p_si = 64'(sq_i) * 64'(sq_i);
  end

  // Stage C: choose the summands for each part and add them.
  always_comb begin
    logic        sa_r, sb_r, sa_i, sb_i;
    logic [63:0] ma_r, mb_r, ma_i, mb_i;
    logic [64:0] sum_r, sum_i;
    sa_r = 1'b0; ma_r = '0; sb_r = 1'b0; mb_r = '0;
    sa_i = 1'b0; ma_i = '0; sb_i = 1'b0; mb_i = '0;
    c_d.is_div    = 1'b0;
    c_d.is_scaled = 1'b0;
    unique case (b_q.kind)
      OP_ADD: begin
        sa_r = b_q.s_ar; ma_r = 64'(b_q.m_ar); sb_r = b_q.s_br; mb_r = 64'(b_q.m_br);
        sa_i = b_q.s_ai; ma_i = 64'(b_q.m_ai); sb_i = b_q.s_bi; mb_i = 64'(b_q.m_bi);
      end
      OP_SUB: begin
        sa_r = b_q.s_ar; ma_r = 64'(b_q.m_ar); sb_r = !b_q.s_br; mb_r = 64'(b_q.m_br);
        sa_i = b_q.s_ai; ma_i = 64'(b_q.m_ai); sb_i = !b_q.s_bi; mb_i = 64'(b_q.m_bi);
      end
      OP_MUL: begin
        c_d.is_scaled = 1'b1;
        sa_r = b_q.s_ar ^ b_q.s_br;    ma_r = b_q.p_rr;
        sb_r = !(b_q.s_ai ^ b_q.s_bi); mb_r = b_q.p_ii;
        sa_i = b_q.s_ar ^ b_q.s_bi;    ma_i = b_q.p_ri;
        sb_i = b_q.s_ai ^ b_q.s_br;    mb_i = b_q.p_ir;
      end
      OP_DIV: begin
        c_d.is_div = 1'b1;
        sa_r = b_q.s_ar ^ b_q.s_br;    ma_r = b_q.p_rr;
        sb_r = b_q.s_ai ^ b_q.s_bi;    mb_r = b_q.p_ii;
        sa_i = b_q.s_ai ^ b_q.s_br;    ma_i = b_q.p_ir;
        sb_i = !(b_q.s_ar ^ b_q.s_bi); mb_i = b_q.p_ri;
      end
      OP_CONJ: begin
        sa_r = b_q.s_ar;  ma_r = 64'(b_q.m_ar); sb_r = sa_r;
        sa_i = !b_q.s_ai; ma_i = 64'(b_q.m_ai); sb_i = sa_i;
      end
      OP_NEG: begin
        sa_r = !b_q.s_ar; ma_r = 64'(b_q.m_ar); sb_r = sa_r;
        sa_i = !b_q.s_ai; ma_i = 64'(b_q.m_ai); sb_i = sa_i;
      end
      OP_MAG: begin
        c_d.is_scaled = 1'b1;
        ma_r = b_q.p_sr; mb_r = b_q.p_si;
      end
      default: ;
    endcase
    sum_r    = sm_add(sa_r, ma_r, sb_r, mb_r);
    sum_i    = sm_add(sa_i, ma_i, sb_i, mb_i);
    c_d.s_re = sum_r[64];
    c_d.m_re = sum_r[63:0];
    c_d.s_im = sum_i[64];
    c_d.m_im = sum_i[63:0];
    c_d.d    = b_q.p_sr + b_q.p_si;
    c_d.zd   = c_d.is_div && (c_d.d == 64'd0);
  end

  // Stage D: finish the non-dividing results and seed both divider lanes.
  always_comb begin
    logic [64:0] v_re, v_im;
    logic [32:0] r_re, r_im;
    logic [NW-1:0] n_re, n_im;
    v_re = c_q.is_scaled ? (({1'b0, c_q.m_re} + RND_HALF) >> FRAC_BITS) : {1'b0, c_q.m_re};
    v_im = c_q.is_scaled ? (({1'b0, c_q.m_im} + RND_HALF) >> FRAC_BITS) : {1'b0, c_q.m_im};
    r_re = sat32(c_q.s_re, v_re);
    r_im = sat32(c_q.s_im, v_im);
    n_re = NW'(c_q.m_re) << FRAC_BITS;
    n_im = NW'(c_q.m_im) << FRAC_BITS;
    e_d.re.rem  = 64'(n_re[NW-1:QBITS]);
    e_d.re.lowq = n_re[QBITS-1:0];
    e_d.re.neg  = c_q.s_re;
    e_d.re.big  = 64'(n_re[NW-1:QBITS]) >= c_q.d;
    e_d.im.rem  = 64'(n_im[NW-1:QBITS]);
    e_d.im.lowq = n_im[QBITS-1:0];
    e_d.im.neg  = c_q.s_im;
    e_d.im.big  = 64'(n_im[NW-1:QBITS]) >= c_q.d;
    e_d.d       = c_q.d;
    e_d.is_div  = c_q.is_div;
    e_d.zd      = c_q.zd;
    e_d.pre_re  = r_re[31:0];
    e_d.pre_im  = r_im[31:0];
    e_d.pre_sat = r_re[32] | r_im[32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      ve_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      e_q <= e_d;
    end
  end

  assign valid_o = ve_q;
  assign data_o  = e_q;

endmodule

// ===== hw/rtl/cau_div_step.sv =====
// One restoring-division stage of the complex arithmetic unit, both lanes
// side by side, one quotient bit each. Uses cau_pkg.
module cau_div_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  cau_pkg::cau_dstage_t data_i,
  output logic                 valid_o,
  output cau_pkg::cau_dstage_t data_o
);
  import cau_pkg::*;

  function automatic cau_dlane_t step(input cau_dlane_t l, input logic [63:0] d);
    cau_dlane_t  r;
    logic [64:0] t, diff;
    logic        ge;
    t      = {l.rem, l.lowq[QBITS-1]};
    diff   = t - {1'b0, d};
    ge     = t >= {1'b0, d};
    r      = l;
    r.rem  = ge ? diff[63:0] : t[63:0];
    r.lowq = {l.lowq[QBITS-2:0], ge};
    return r;
  endfunction

  cau_dstage_t data_d, data_q;
  logic        valid_q;

  always_comb begin
    data_d    = data_i;
    data_d.re = step(data_i.re, data_i.d);
    data_d.im = step(data_i.im, data_i.d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/cau_final.sv =====
// Result formation of the complex arithmetic unit: quotient rounding,
// saturation and the choice between quotient and early result. Uses cau_pkg.
module cau_final (
  input  cau_pkg::cau_dstage_t data_i,
  output cau_pkg::cau_out_t    res_o
);
  import cau_pkg::*;

  // Round half away from zero on the magnitude, then clamp.
  function automatic logic [32:0] finish(input cau_dlane_t l, input logic [63:0] d);
    logic [32:0] qr;
    logic        up;
    logic [64:0] m;
    up = {l.rem, 1'b0} >= {1'b0, d};
    qr = {1'b0, l.lowq} + 33'(up);
    m  = l.big ? 65'h2_0000_0000 : 65'(qr);
    return sat32(l.neg, m);
  endfunction

  always_comb begin
    logic [32:0] q_re, q_im;
    q_re = finish(data_i.re, data_i.d);
    q_im = finish(data_i.im, data_i.d);
    if (data_i.zd) begin
      res_o.res_re       = '0;
      res_o.res_im       = '0;
      res_o.zero_divisor = 1'b1;
      res_o.saturated    = 1'b0;
    end else if (data_i.is_div) begin
      res_o.res_re       = q_re[31:0];
      res_o.res_im       = q_im[31:0];
      res_o.zero_divisor = 1'b0;
      res_o.saturated    = q_re[32] | q_im[32];
    end else begin
      res_o.res_re       = data_i.pre_re;
      res_o.res_im       = data_i.pre_im;
      res_o.zero_divisor = 1'b0;
      res_o.saturated    = data_i.pre_sat;
    end
  end

endmodule

// ===== hw/rtl/complex_arithmetic_unit_top.sv =====
// Top level of the complex arithmetic unit: front end, divider stages,
// result formation and the output register with skid stage. Uses cau_pkg.
//
// Usage: an input beat carries an operation code and two complex operands in
// signed Q16.16; each beat gives exactly one result beat, in order. Both
// channels use a valid/ready handshake and a beat moves on a rising clock edge
// at which valid and ready are both high.
// Pipeline: a result passes through four front-end stages (operand split,
// multiply, sum, divider set-up), one stage per quotient bit of the restoring
// divider (32), and the output register.
// Every operation goes through the same fixed-length pipeline, so results
// leave in the order the beats came in.
// Throughput: one beat per cycle for any mix of operations, while the skid stage is empty.
// Reset: the asynchronous active-low reset empties every stage; no result is
// pending afterwards and the block is ready at once.
// Stall: when the receiver holds ready low, the waiting result stays on the
// output and the next finished result goes to the skid stage. Only while the
// skid stage is full does the pipeline halt and input ready go low.
module complex_arithmetic_unit_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cau_pkg::cau_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cau_pkg::cau_out_t out_data_o
);
  import cau_pkg::*;

  // Stage k of the divider chain; entry 0 is the front-end output.
  cau_dstage_t stg [QBITS+1];
  logic        vld [QBITS+1];
  logic        en;
  cau_out_t    res;

  cau_out_t out_d, out_q, skid_d, skid_q;
  logic     out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;

  // The whole pipeline advances unless the skid stage holds a beat.
  assign en = !skid_valid_q;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (vld[0]),
    .data_o  (stg[0])
  );

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    cau_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[k]),
      .data_i  (stg[k]),
      .valid_o (vld[k+1]),
      .data_o  (stg[k+1])
    );
  end

  cau_final u_final (
    .data_i (stg[QBITS]),
    .res_o  (res)
  );

  // Output register and skid stage. The skid stage only fills when the output
  // register is held by the receiver, and it drains first once ready returns.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (vld[QBITS]) begin
      if (out_valid_q && !out_ready_i) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = res;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/cau_checker.sv =====
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Uses cau_pkg for the beat types.
module cau_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input cau_pkg::cau_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cau_pkg::cau_out_t out_data_o
);
  import cau_pkg::*;

  // A held result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Input back-pressure only ever comes with a result waiting.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  // A zero divisor gives a clean zero result.
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_divisor |->
      out_data_o.res_re == 32'sd0 && out_data_o.res_im == 32'sd0 && !out_data_o.saturated)
    else $error("zero divisor result not zero");

  // A clamped result shows a range limit in one of its parts.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.res_re == 32'h7FFF_FFFF || out_data_o.res_re == 32'h8000_0000 ||
      out_data_o.res_im == 32'h7FFF_FFFF || out_data_o.res_im == 32'h8000_0000)
    else $error("saturation flag without a clamped part");

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_data_i);

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
